FILE: sv/gpa_pkg.sv
// Shared types and constants for the grouped pricing aggregation unit.
package gpa_pkg;

  localparam int SUM_W      = 64;
  localparam int CNT_W      = 32;
  localparam int PCT_W      = 7;
  localparam int KEY_BITS_D = 16;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  typedef struct packed {
    logic [SUM_W-1:0] qty;
    logic [SUM_W-1:0] disc;
    logic [SUM_W-1:0] price;
    logic [SUM_W-1:0] dprice;
    logic [SUM_W-1:0] charge;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

FILE: sv/grouped_pricing_aggregation_unit.sv
// Top level of the grouped pricing aggregation unit with its sequencer.
// After reset the unit clears every entry of its group store, one entry per cycle,
// and takes no word meanwhile. A record (tuser 0) then goes through one store read,
// two chained multiplies and one write back. A group read (tuser 1) uses one shared
// bit-serial divider that works out the three averages in turn; an empty group skips the
// divider. One word is handled at a time; a result waits in the output register while
// the next word is accepted.
module grouped_pricing_aggregation_unit #(
  parameter int GROUP_KEY_BITS = gpa_pkg::KEY_BITS_D
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // return_flag, line_status, quantity, extended_price, discount, tax_rate
  input  logic [63:0]  in_tdata,
  // mode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // quantity sum, base price sum, discounted price sum, charge sum,
  // mean quantity, mean price, mean discount, record count
  output logic [423:0] out_tdata,
  // group_found
  output logic         out_tuser
);

  localparam int SW = gpa_pkg::SUM_W;
  localparam int CW = gpa_pkg::CNT_W;
  localparam int PW = gpa_pkg::PCT_W;
  localparam int KB = GROUP_KEY_BITS;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_DQ    = 4'd7;
  localparam logic [3:0] S_DP    = 4'd8;
  localparam logic [3:0] S_DD    = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [KB:0]   clr_r, clr_nxt;
  logic          mode_r;
  logic [KB-1:0] key_r;
  logic [7:0]    qty_r;
  logic [23:0]   price_r;
  logic [PW-1:0] disc_r, tax_r;
  logic [30:0]   dprice_r, dprice_nxt;
  logic [38:0]   charge_r, charge_nxt;
  logic [SW-1:0] avgq_r, avgq_nxt, avgp_r, avgp_nxt;
  logic [PW-1:0] avgd_r, avgd_nxt;
  logic          found_r, found_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [423:0]  out_data_r;
  logic          out_user_r;
  logic          load_out;

  logic [PW-1:0] disc_in, tax_in;
  logic [15:0]   key_full;

  gpa_pkg::entry_t  rd_data, wr_data;
  logic             wr_en, rd_en;
  logic [KB-1:0]    wr_addr;
  gpa_pkg::div_req_t div_req;
  logic             div_done;
  logic [SW-1:0]    div_q;

  assign in_tready = (state_r == S_IDLE);
  assign key_full  = in_tdata[15:0];
  assign disc_in   = (in_tdata[54:48] > gpa_pkg::PCT_FULL) ? gpa_pkg::PCT_FULL
                                                           : in_tdata[54:48];
  assign tax_in    = (in_tdata[61:55] > gpa_pkg::PCT_FULL) ? gpa_pkg::PCT_FULL
                                                           : in_tdata[61:55];

  gpa_store #(.KEY_BITS(KB)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(key_r), .rd_data(rd_data)
  );

  gpa_divider u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    dprice_nxt = dprice_r;
    charge_nxt = charge_r;
    avgq_nxt   = avgq_r;
    avgp_nxt   = avgp_r;
    avgd_nxt   = avgd_r;
    found_nxt  = found_r;
    wr_en      = 1'b0;
    wr_addr    = key_r;
    wr_data    = '0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    div_req    = '0;
    div_req.divisor = rd_data.cnt;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r[KB-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (KB+1)'((2**KB) - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = mode_r ? S_CHK : S_MUL1;
      end
      S_MUL1: begin
        dprice_nxt = 31'(price_r) * 31'(gpa_pkg::PCT_FULL - disc_r);
        state_nxt  = S_MUL2;
      end
      S_MUL2: begin
        charge_nxt = 39'(dprice_r) * 39'({1'b0, gpa_pkg::PCT_FULL} + {1'b0, tax_r});
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        wr_en          = 1'b1;
        wr_data.qty    = gpa_pkg::sat_add(rd_data.qty, SW'(qty_r));
        wr_data.disc   = gpa_pkg::sat_add(rd_data.disc, SW'(disc_r));
        wr_data.price  = gpa_pkg::sat_add(rd_data.price, SW'(price_r));
        wr_data.dprice = gpa_pkg::sat_add(rd_data.dprice, SW'(dprice_r));
        wr_data.charge = gpa_pkg::sat_add(rd_data.charge, SW'(charge_r));
        wr_data.cnt    = (&rd_data.cnt) ? rd_data.cnt : rd_data.cnt + CW'(1);
        state_nxt      = S_IDLE;
      end
      S_CHK: begin
        found_nxt = (rd_data.cnt != '0);
        avgq_nxt  = '0;
        avgp_nxt  = '0;
        avgd_nxt  = '0;
        if (rd_data.cnt != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = rd_data.qty;
          state_nxt        = S_DQ;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DQ: begin
        if (div_done) begin
          avgq_nxt         = div_q;
          div_req.start    = 1'b1;
          div_req.dividend = rd_data.price;
          state_nxt        = S_DP;
        end
      end
      S_DP: begin
        if (div_done) begin
          avgp_nxt         = div_q;
          div_req.start    = 1'b1;
          div_req.dividend = rd_data.disc;
          state_nxt        = S_DD;
        end
      end
      S_DD: begin
        if (div_done) begin
          avgd_nxt  = (div_q > SW'(gpa_pkg::PCT_FULL)) ? gpa_pkg::PCT_FULL : div_q[PW-1:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      mode_r  <= in_tuser;
      key_r   <= key_full[KB-1:0];
      qty_r   <= in_tdata[23:16];
      price_r <= in_tdata[47:24];
      disc_r  <= disc_in;
      tax_r   <= tax_in;
    end
    dprice_r <= dprice_nxt;
    charge_r <= charge_nxt;
    avgq_r   <= avgq_nxt;
    avgp_r   <= avgp_nxt;
    avgd_r   <= avgd_nxt;
    found_r  <= found_nxt;
    if (load_out) begin
      out_user_r <= found_r;
      if (found_r) begin
        out_data_r <= {1'b0, rd_data.cnt, avgd_r, avgp_r, avgq_r, rd_data.charge,
                       rd_data.dprice, rd_data.price, rd_data.qty};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: sv/gpa_divider.sv
// Restoring divider that yields one quotient bit per cycle.
module gpa_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gpa_pkg::div_req_t        req,
  output logic                     done,
  output logic [gpa_pkg::SUM_W-1:0] quotient
);

  localparam int SW = gpa_pkg::SUM_W;
  localparam int CW = gpa_pkg::CNT_W;
  localparam int NB = $clog2(SW);

  logic [SW-1:0]         quo_r, quo_nxt;
  logic [CW-1:0]         rem_r, rem_nxt;
  logic [CW-1:0]         dvs_r, dvs_nxt;
  logic [NB-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW:0]           rem_sh;
  logic [CW:0]           diff;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, quo_r[SW-1]};
    diff     = rem_sh - {1'b0, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[CW]) begin
        rem_nxt = diff[CW-1:0];
        quo_nxt = {quo_r[SW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[CW-1:0];
        quo_nxt = {quo_r[SW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + NB'(1);
      if (cnt_r == NB'(SW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: sv/gpa_store.sv
// Group entry memory with one write port and one registered read port.
module gpa_store #(
  parameter int KEY_BITS = gpa_pkg::KEY_BITS_D
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [KEY_BITS-1:0] wr_addr,
  input  gpa_pkg::entry_t     wr_data,
  input  logic                rd_en,
  input  logic [KEY_BITS-1:0] rd_addr,
  output gpa_pkg::entry_t     rd_data
);

  gpa_pkg::entry_t mem [2**KEY_BITS];
  gpa_pkg::entry_t rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_r;

endmodule
